### src/mbrtu_pkg.sv
package mbrtu_pkg;

   localparam logic [7:0]  FnReadCoils   = 8'd1;
   localparam logic [7:0]  FnReadHolding = 8'd3;
   localparam logic [7:0]  FnReadInput   = 8'd4;
   localparam logic [15:0] ReplyBase     = 16'd5;
   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPoly       = 16'hA001;

   typedef enum logic [2:0] {
      POS_ADDR,
      POS_FUNC,
      POS_REG_HI,
      POS_REG_LO,
      POS_DATA_HI,
      POS_DATA_LO,
      POS_CRC_LO,
      POS_CRC_HI
   } byte_pos_type;

   typedef struct packed {
      logic [7:0]  slave_addr;
      logic [7:0]  func_code;
      logic [15:0] reg_addr;
      logic [15:0] data_word;
      logic        expect_reply;
      logic [15:0] reply_length;
   } frame_fields_type;

endpackage

### src/mbrtu_if.sv
interface mbrtu_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  slave_addr;
   logic [7:0]  func_code;
   logic [15:0] reg_addr;
   logic [15:0] quantity;
   logic        want_reply;

   modport source (output valid, output slave_addr, output func_code, output reg_addr,
                   output quantity, output want_reply, input ready);
   modport sink (input valid, input slave_addr, input func_code, input reg_addr,
                 input quantity, input want_reply, output ready);
endinterface

interface mbrtu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tx_byte;
   logic        last_byte;
   logic        expect_reply;
   logic [15:0] reply_length;

   modport source (output valid, output tx_byte, output last_byte, output expect_reply,
                   output reply_length, input ready);
   modport sink (input valid, input tx_byte, input last_byte, input expect_reply,
                 input reply_length, output ready);
endinterface

### src/mbrtu_crc_byte.sv
module mbrtu_crc_byte (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ mbrtu_pkg::CrcPoly;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

### src/modbus_rtu_request_framer.sv
// modbus rtu request framer
// req_ch (sink): one request word per accepted transfer: slave address, function
//   code, register address, quantity and the reply-wanted flag
// rsp_ch (source): eight byte words per request in transmission order: address,
//   function, register address hi/lo, data word hi/lo, crc-16 lo/hi; last_byte marks
//   the crc high byte; every word also carries expect_reply and reply_length
// the first byte word passes the request register and the serializer and is then
//   registered in the output register; the byte serializer sends one byte word per
//   cycle while the receiver is ready and folds each header byte into the crc as sent
// a one-deep request register takes the next request while the current frame is
//   still being sent, so frames follow each other with no gap
// when the receiver stalls, the output register holds its word and the serializer
//   waits; req_ch.ready drops once the request register is full
// reset (synchronous, active high) empties the request register, the serializer
//   and the output register; no partial frame is kept
module modbus_rtu_request_framer (
   input logic          clock,
   input logic          reset,
   mbrtu_req_if.sink    req_ch,
   mbrtu_rsp_if.source  rsp_ch
);

   logic                        pend_valid_ff, pend_valid_in;
   mbrtu_pkg::frame_fields_type pend_ff, pend_in;
   logic                        busy_ff, busy_in;
   mbrtu_pkg::frame_fields_type cur_ff, cur_in;
   mbrtu_pkg::byte_pos_type     pos_ff, pos_in;
   logic [15:0]                 crc_ff, crc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_expect_ff, rsp_expect_in;
   logic [15:0]                 rsp_len_ff, rsp_len_in;

   logic        req_take;
   logic        issue;
   logic        load_cur;
   logic [7:0]  byte_sel;
   logic [15:0] crc_upd;
   logic [15:0] coil_bytes;

   assign req_ch.ready = !pend_valid_ff;
   assign req_take     = req_ch.valid && req_ch.ready;

   // request decode
   always_comb begin
      coil_bytes = {3'b000, req_ch.quantity[15:3]} + {15'd0, (req_ch.quantity[2:0] != 3'd0)};
      pend_in.slave_addr   = req_ch.slave_addr;
      pend_in.func_code    = req_ch.func_code;
      pend_in.reg_addr     = req_ch.reg_addr;
      pend_in.expect_reply = req_ch.want_reply;
      if (req_ch.func_code == mbrtu_pkg::FnReadCoils) begin
         pend_in.data_word = coil_bytes;
      end else begin
         pend_in.data_word = req_ch.quantity;
      end
      if (!req_ch.want_reply) begin
         pend_in.reply_length = 16'd0;
      end else if (req_ch.func_code == mbrtu_pkg::FnReadCoils) begin
         pend_in.reply_length = mbrtu_pkg::ReplyBase + coil_bytes;
      end else if (req_ch.func_code == mbrtu_pkg::FnReadHolding ||
                   req_ch.func_code == mbrtu_pkg::FnReadInput) begin
         pend_in.reply_length = mbrtu_pkg::ReplyBase + {req_ch.quantity[14:0], 1'b0};
      end else begin
         pend_in.reply_length = mbrtu_pkg::ReplyBase;
      end
   end

   assign issue    = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign load_cur = !busy_ff || (issue && pos_ff == mbrtu_pkg::POS_CRC_HI);

   always_comb begin
      case (pos_ff)
         mbrtu_pkg::POS_ADDR:    byte_sel = cur_ff.slave_addr;
         mbrtu_pkg::POS_FUNC:    byte_sel = cur_ff.func_code;
         mbrtu_pkg::POS_REG_HI:  byte_sel = cur_ff.reg_addr[15:8];
         mbrtu_pkg::POS_REG_LO:  byte_sel = cur_ff.reg_addr[7:0];
         mbrtu_pkg::POS_DATA_HI: byte_sel = cur_ff.data_word[15:8];
         mbrtu_pkg::POS_DATA_LO: byte_sel = cur_ff.data_word[7:0];
         mbrtu_pkg::POS_CRC_LO:  byte_sel = crc_ff[7:0];
         mbrtu_pkg::POS_CRC_HI:  byte_sel = crc_ff[15:8];
         default:                byte_sel = cur_ff.slave_addr;
      endcase
   end

   mbrtu_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (byte_sel),
      .crc_next  (crc_upd)
   );

   always_comb begin
      pend_valid_in = pend_valid_ff;
      busy_in       = busy_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      if (issue) begin
         pos_in = mbrtu_pkg::byte_pos_type'(pos_ff + 3'd1);
         if (pos_ff != mbrtu_pkg::POS_CRC_LO && pos_ff != mbrtu_pkg::POS_CRC_HI) begin
            crc_in = crc_upd;
         end
      end
      if (load_cur) begin
         busy_in = pend_valid_ff;
         cur_in  = pend_ff;
         pos_in  = mbrtu_pkg::POS_ADDR;
         crc_in  = mbrtu_pkg::CrcInit;
         if (pend_valid_ff) begin
            pend_valid_in = 1'b0;
         end
      end
      if (req_take) begin
         pend_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_expect_in = rsp_expect_ff;
      rsp_len_in    = rsp_len_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (issue) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = byte_sel;
         rsp_last_in   = (pos_ff == mbrtu_pkg::POS_CRC_HI);
         rsp_expect_in = cur_ff.expect_reply;
         rsp_len_in    = cur_ff.reply_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         pos_ff        <= mbrtu_pkg::POS_ADDR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         busy_ff       <= busy_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pend_ff <= pend_in;
      end
      cur_ff        <= cur_in;
      crc_ff        <= crc_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_expect_ff <= rsp_expect_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.tx_byte      = rsp_byte_ff;
   assign rsp_ch.last_byte    = rsp_last_ff;
   assign rsp_ch.expect_reply = rsp_expect_ff;
   assign rsp_ch.reply_length = rsp_len_ff;

   a_last_marks_crc_hi: assert property (@(posedge clock) disable iff (reset)
      issue && pos_ff == mbrtu_pkg::POS_CRC_HI |=> rsp_valid_ff && rsp_last_ff)
      else $error("crc high byte not marked last");

   a_mid_frame_stays_busy: assert property (@(posedge clock) disable iff (reset)
      issue && pos_ff != mbrtu_pkg::POS_CRC_HI |=> busy_ff && !rsp_last_ff)
      else $error("frame ended early");

   a_pending_starts: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !busy_ff |=> busy_ff && pos_ff == mbrtu_pkg::POS_ADDR)
      else $error("pending request not started");

   a_take_fills_pending: assert property (@(posedge clock) disable iff (reset)
      req_take |=> pend_valid_ff)
      else $error("accepted request lost");

endmodule
